>>> rtl/ssh_pkg.sv
// shared types, widths and helpers for the size statistics histogram
// no dependencies; imported by every module of the block
package ssh_pkg;

    localparam int BIN_COUNT_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int SIZE_W = 32;
    localparam int SUM_W  = 64;
    localparam int CNT_W  = 32;
    localparam int SEL_W  = 5;
    localparam int IDX_W  = 7;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] sample_size;
        logic [SEL_W-1:0]  bin_select;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0]  sample_total;
        logic [SUM_W-1:0]  size_sum;
        logic [SIZE_W-1:0] smallest;
        logic [SIZE_W-1:0] largest;
        logic [CNT_W-1:0]  mean_size;
        logic [CNT_W-1:0]  bin_value;
        logic [SEL_W-1:0]  lowest_bin;
        logic [SEL_W-1:0]  highest_bin;
    } t_out_word;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] mean;
    } t_div_stat;

    // number of significant bits, 0 for a zero value
    function automatic logic [IDX_W-1:0] bit_length(input logic [SIZE_W-1:0] v);
        logic [IDX_W-1:0] n;
        n = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                n = IDX_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/ssh_bin_mem.sv
// histogram bin counter memory, one read or write port, registered read
// per-entry valid bits give zeroed bins after reset; uses ssh_pkg
module ssh_bin_mem #(
    parameter int BIN_COUNT = ssh_pkg::BIN_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ssh_pkg::t_mem_req       i_req,
    output logic [ssh_pkg::CNT_W-1:0] o_rd_data
);
    import ssh_pkg::*;

    localparam int BIN_W = $clog2(BIN_COUNT);

    logic [CNT_W-1:0]     r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_valid;
    logic [CNT_W-1:0]     r_rd_data;
    logic [BIN_W-1:0]     w_addr;

    assign w_addr    = i_req.idx[BIN_W-1:0];
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[w_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[w_addr] ? r_mem[w_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

endmodule

>>> rtl/ssh_mean_div.sv
// ceiling mean unit: restoring divide of the sum by the count, one bit a cycle
// saturates the mean to the count width; uses ssh_pkg
module ssh_mean_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssh_pkg::t_div_ctl  i_ctl,
    output ssh_pkg::t_div_stat o_stat
);
    import ssh_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W:0]    r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_den;

    logic [CNT_W:0]    w_shift;
    logic              w_ge;
    logic              w_hi_nz;
    logic [CNT_W:0]    w_inc;

    assign w_shift = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_hi_nz = |r_quo[SUM_W-1:CNT_W];
    assign w_inc   = {1'b0, r_quo[CNT_W-1:0]} + (CNT_W + 1)'(r_rem != '0);

    assign o_stat.done = r_done;
    assign o_stat.mean = (w_hi_nz || w_inc[CNT_W]) ? '1 : w_inc[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_ctl.dividend;
            r_den <= i_ctl.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/size_stats_log2_histogram.sv
// size statistics collector: count, saturating sum, min, max, log2 histogram
// top level; uses ssh_pkg, ssh_bin_mem and ssh_mean_div
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------
//   in      | input     | i_in_valid / o_in_ready | t_in_word
//   out     | output    | o_out_valid / i_out_ready | t_out_word
//
// an add reads the bin memory, then modifies and writes it back
// a read with samples present also runs the 64-step mean divider
// reset clears all statistics at once, the bins through per-bin valid bits, no sweep
// the output register holds one word; a stalled output blocks a second finished word
module size_stats_log2_histogram #(
    parameter int BIN_COUNT   = ssh_pkg::BIN_COUNT_DEF,
    parameter int SAMPLE_BITS = ssh_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssh_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssh_pkg::t_out_word o_out_word
);
    import ssh_pkg::*;

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int SW    = (SAMPLE_BITS < SIZE_W) ? SAMPLE_BITS : SIZE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_DIV,
        S_HOLD
    } t_state_e;

    t_state_e         r_state, n_state;
    logic             r_op, n_op;
    logic [SW-1:0]    r_size, n_size;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SW-1:0]    r_min, n_min;
    logic [SW-1:0]    r_max, n_max;
    logic [BIN_W-1:0] r_low_bin, n_low_bin;
    logic [BIN_W-1:0] r_high_bin, n_high_bin;
    logic             r_any_binned, n_any_binned;
    t_out_word        r_res, n_res;
    t_out_word        r_out_word, n_out_word;
    logic             r_out_valid, n_out_valid;

    t_mem_req         w_mem_req;
    logic [CNT_W-1:0] w_rd_data;
    t_div_ctl         w_div_ctl;
    t_div_stat        w_div_stat;

    logic [SW-1:0]    w_size;
    logic [IDX_W-1:0] w_blen;
    logic             w_in_range;
    logic             w_out_free;
    logic [SUM_W:0]   w_sum_ext;
    logic [IDX_W-1:0] w_low_ext;
    logic [IDX_W-1:0] w_high_ext;

    ssh_bin_mem #(
        .BIN_COUNT (BIN_COUNT)
    ) u_bin_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    ssh_mean_div u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_stat  (w_div_stat)
    );

    assign w_size     = i_in_word.sample_size[SW-1:0];
    assign w_blen     = bit_length(SIZE_W'(w_size));
    assign w_in_range = r_idx < IDX_W'(BIN_COUNT);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(r_size);
    assign w_low_ext  = IDX_W'(n_low_bin);
    assign w_high_ext = IDX_W'(n_high_bin);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_size       = r_size;
        n_idx        = r_idx;
        n_count      = r_count;
        n_sum        = r_sum;
        n_min        = r_min;
        n_max        = r_max;
        n_low_bin    = r_low_bin;
        n_high_bin   = r_high_bin;
        n_any_binned = r_any_binned;
        n_res        = r_res;
        n_out_word   = r_out_word;
        n_out_valid  = r_out_valid && !i_out_ready;

        w_mem_req          = '0;
        w_mem_req.idx      = r_idx;
        w_div_ctl.start    = 1'b0;
        w_div_ctl.dividend = r_sum;
        w_div_ctl.divisor  = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = i_in_word.operation;
                    n_size = w_size;
                    n_idx  = (i_in_word.operation == OP_READ) ?
                             IDX_W'(i_in_word.bin_select) : w_blen;
                    w_mem_req.rd_en = 1'b1;
                    w_mem_req.idx   = n_idx;
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                if (r_op == OP_ADD) begin
                    if (r_count == '0) begin
                        n_min = r_size;
                        n_max = r_size;
                    end else begin
                        if (r_size > r_max) n_max = r_size;
                        if (r_size < r_min) n_min = r_size;
                    end
                    if (r_count != '1) n_count = r_count + 1'b1;
                    n_sum = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
                    if (w_in_range) begin
                        w_mem_req.wr_en   = 1'b1;
                        w_mem_req.wr_data = (w_rd_data != '1) ? w_rd_data + 1'b1
                                                              : w_rd_data;
                        n_any_binned = 1'b1;
                        if (!r_any_binned || r_idx[BIN_W-1:0] < r_low_bin) begin
                            n_low_bin = r_idx[BIN_W-1:0];
                        end
                        if (!r_any_binned || r_idx[BIN_W-1:0] > r_high_bin) begin
                            n_high_bin = r_idx[BIN_W-1:0];
                        end
                    end
                end
                n_res.sample_total = n_count;
                n_res.size_sum     = n_sum;
                n_res.smallest     = SIZE_W'(n_min);
                n_res.largest      = SIZE_W'(n_max);
                n_res.mean_size    = '0;
                n_res.bin_value    = (r_op == OP_READ && w_in_range) ? w_rd_data : '0;
                n_res.lowest_bin   = w_low_ext[SEL_W-1:0];
                n_res.highest_bin  = w_high_ext[SEL_W-1:0];
                if (r_op == OP_READ && r_count != '0) begin
                    w_div_ctl.start = 1'b1;
                    n_state = S_DIV;
                end else if (w_out_free) begin
                    n_out_word  = n_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_res.mean_size = w_div_stat.mean;
                    if (w_out_free) begin
                        n_out_word  = n_res;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_word  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_size     <= n_size;
        r_idx      <= n_idx;
        r_res      <= n_res;
        r_out_word <= n_out_word;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_sum        <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_low_bin    <= '0;
            r_high_bin   <= '0;
            r_any_binned <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_sum        <= n_sum;
            r_min        <= n_min;
            r_max        <= n_max;
            r_low_bin    <= n_low_bin;
            r_high_bin   <= n_high_bin;
            r_any_binned <= n_any_binned;
            r_out_valid  <= n_out_valid;
        end
    end

    a_accept_to_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_RMW))
        else $error("accepted word did not enter read-modify-write");

    a_mem_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_req.rd_en && w_mem_req.wr_en))
        else $error("bin memory read and write in the same cycle");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.start |-> (r_count != '0))
        else $error("mean divider started with a zero count");

    a_empty_bins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any_binned |-> (r_low_bin == '0 && r_high_bin == '0))
        else $error("bin range set while no bin is filled");

endmodule

>>> dv/tb_size_stats_log2_histogram.sv
// testbench for size_stats_log2_histogram: directed table, then random adds and reads
// predicts count, sum, min, max, mean and histogram bins; needs ssh_pkg and the rtl only
module tb_size_stats_log2_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import ssh_pkg::*;

    localparam int NBINS        = BIN_COUNT_DEF;
    localparam int WATCH_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 630;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct {
        t_in_word  w;
        bit        fixed;
        t_out_word exp;
    } t_stim;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;

    size_stats_log2_histogram u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #4 i_clk = ~i_clk;

    // predicted statistics state
    logic [CNT_W-1:0]  pr_count;
    logic [SUM_W-1:0]  pr_sum;
    logic [SIZE_W-1:0] pr_min;
    logic [SIZE_W-1:0] pr_max;
    logic [CNT_W-1:0]  pr_bins [NBINS];
    logic [SEL_W-1:0]  pr_lo;
    logic [SEL_W-1:0]  pr_hi;
    bit                pr_any;

    t_stim     pending_words [$];
    t_out_word expected_stats [$];

    int  send_idle_pct = 16;
    int  recv_idle_pct = 60;
    bit  hold_wanted   = 1'b0;
    bit  hold_used     = 1'b0;
    int  hold_left     = 0;
    int  mismatches    = 0;
    int  words_in      = 0;
    int  words_out     = 0;
    int  reads_in      = 0;
    int  oversized_in  = 0;
    int  quiet_cycles  = 0;

    function automatic t_out_word stats_update(input t_in_word w);
        t_out_word         r;
        int                d;
        logic [SIZE_W-1:0] v;
        logic [SUM_W:0]    q;
        r = '0;
        if (w.operation == OP_ADD) begin
            v = w.sample_size;
            d = 0;
            while (v != '0) begin
                d++;
                v = v >> 1;
            end
            if (pr_count == '0) begin
                pr_min = w.sample_size;
                pr_max = w.sample_size;
            end else begin
                if (w.sample_size > pr_max) pr_max = w.sample_size;
                if (w.sample_size < pr_min) pr_min = w.sample_size;
            end
            if (pr_count != CNT_MAX) pr_count = pr_count + 1'b1;
            if (pr_sum > (SUM_MAX - {32'b0, w.sample_size})) begin
                pr_sum = SUM_MAX;
            end else begin
                pr_sum = pr_sum + {32'b0, w.sample_size};
            end
            if (d < NBINS) begin
                if (pr_bins[SEL_W'(d)] != CNT_MAX) begin
                    pr_bins[SEL_W'(d)] = pr_bins[SEL_W'(d)] + 1'b1;
                end
                if (!pr_any) begin
                    pr_lo  = SEL_W'(d);
                    pr_hi  = SEL_W'(d);
                    pr_any = 1'b1;
                end else begin
                    if (d < pr_lo) pr_lo = SEL_W'(d);
                    if (d > pr_hi) pr_hi = SEL_W'(d);
                end
            end
        end else begin
            if (pr_count != '0) begin
                q = {1'b0, pr_sum / {32'b0, pr_count}};
                if ((pr_sum % {32'b0, pr_count}) != '0) q = q + 1'b1;
                r.mean_size = (q > {33'b0, CNT_MAX}) ? CNT_MAX : q[CNT_W-1:0];
            end
            r.bin_value = pr_bins[w.bin_select];
        end
        r.sample_total = pr_count;
        r.size_sum     = pr_sum;
        r.smallest     = pr_min;
        r.largest      = pr_max;
        r.lowest_bin   = pr_any ? pr_lo : '0;
        r.highest_bin  = pr_any ? pr_hi : '0;
        return r;
    endfunction

    function automatic t_out_word stats_word(input logic [CNT_W-1:0] total,
                                             input logic [SUM_W-1:0] sum,
                                             input logic [SIZE_W-1:0] mn,
                                             input logic [SIZE_W-1:0] mx,
                                             input logic [CNT_W-1:0] mean,
                                             input logic [CNT_W-1:0] binv,
                                             input logic [SEL_W-1:0] lo,
                                             input logic [SEL_W-1:0] hi);
        t_out_word r;
        r.sample_total = total;
        r.size_sum     = sum;
        r.smallest     = mn;
        r.largest      = mx;
        r.mean_size    = mean;
        r.bin_value    = binv;
        r.lowest_bin   = lo;
        r.highest_bin  = hi;
        return r;
    endfunction

    function automatic t_stim stim_row(input logic op, input logic [SIZE_W-1:0] sz,
                                       input logic [SEL_W-1:0] sel, input bit fixed,
                                       input t_out_word exp);
        t_stim s;
        s.w.operation   = op;
        s.w.sample_size = sz;
        s.w.bin_select  = sel;
        s.fixed         = fixed;
        s.exp           = exp;
        return s;
    endfunction

    // sizes spread over every bit length, plus the extremes
    function automatic logic [SIZE_W-1:0] random_size();
        int              len;
        logic [SIZE_W:0] mask;
        logic [SIZE_W:0] v;
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return '1;
                    default: return 32'h8000_0000;
                endcase
            end
            default: begin
                len = $urandom_range(SIZE_W);
                if (len == 0) return '0;
                mask = (33'd1 << len) - 1'b1;
                v = ({1'b0, 32'($urandom)} | (33'd1 << (len - 1))) & mask;
                return v[SIZE_W-1:0];
            end
        endcase
    endfunction

    initial begin
        for (int i = 0; i < NBINS; i++) pr_bins[SEL_W'(i)] = '0;
        pr_count = '0;
        pr_sum   = '0;
        pr_min   = '0;
        pr_max   = '0;
        pr_lo    = '0;
        pr_hi    = '0;
        pr_any   = 1'b0;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                t_stim     s;
                t_out_word p;
                s = pending_words.pop_front();
                p = stats_update(s.w);
                expected_stats.push_back(s.fixed ? s.exp : p);
                words_in++;
                if (s.w.operation == OP_READ) reads_in++;
                else if (s.w.sample_size[SIZE_W-1]) oversized_in++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words[0].w;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_out_word want;
                words_out++;
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, o_out_word);
                    mismatches++;
                end else begin
                    want = expected_stats.pop_front();
                    if (o_out_word.sample_total !== want.sample_total) begin
                        $display("%0t: sample_total exp %0d got %0d", $time,
                                 want.sample_total, o_out_word.sample_total);
                        mismatches++;
                    end
                    if (o_out_word.size_sum !== want.size_sum) begin
                        $display("%0t: size_sum exp %0d got %0d", $time,
                                 want.size_sum, o_out_word.size_sum);
                        mismatches++;
                    end
                    if (o_out_word.smallest !== want.smallest) begin
                        $display("%0t: smallest exp %0d got %0d", $time,
                                 want.smallest, o_out_word.smallest);
                        mismatches++;
                    end
                    if (o_out_word.largest !== want.largest) begin
                        $display("%0t: largest exp %0d got %0d", $time,
                                 want.largest, o_out_word.largest);
                        mismatches++;
                    end
                    if (o_out_word.mean_size !== want.mean_size) begin
                        $display("%0t: mean_size exp %0d got %0d", $time,
                                 want.mean_size, o_out_word.mean_size);
                        mismatches++;
                    end
                    if (o_out_word.bin_value !== want.bin_value) begin
                        $display("%0t: bin_value exp %0d got %0d", $time,
                                 want.bin_value, o_out_word.bin_value);
                        mismatches++;
                    end
                    if (o_out_word.lowest_bin !== want.lowest_bin) begin
                        $display("%0t: lowest_bin exp %0d got %0d", $time,
                                 want.lowest_bin, o_out_word.lowest_bin);
                        mismatches++;
                    end
                    if (o_out_word.highest_bin !== want.highest_bin) begin
                        $display("%0t: highest_bin exp %0d got %0d", $time,
                                 want.highest_bin, o_out_word.highest_bin);
                        mismatches++;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_wanted && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || expected_stats.size() != 0);
    endtask

    t_stim     dir_table [22];
    t_out_word zero_word;

    initial begin
        t_in_word w;
        zero_word = '0;
        // first sample is zero, so the sum stays zero while the count moves
        dir_table[0]  = stim_row(OP_READ, 32'h0, 5'd0, 1'b1, zero_word);
        dir_table[1]  = stim_row(OP_READ, '1, 5'd31, 1'b1, zero_word);
        dir_table[2]  = stim_row(OP_ADD, 32'h0, 5'd31, 1'b1,
                                 stats_word(32'd1, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                            5'd0, 5'd0));
        dir_table[3]  = stim_row(OP_READ, 32'h0, 5'd0, 1'b1,
                                 stats_word(32'd1, 64'd0, 32'd0, 32'd0, 32'd0, 32'd1,
                                            5'd0, 5'd0));
        dir_table[4]  = stim_row(OP_READ, 32'h0, 5'd1, 1'b1,
                                 stats_word(32'd1, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                            5'd0, 5'd0));
        dir_table[5]  = stim_row(OP_ADD, '1, 5'd0, 1'b1,
                                 stats_word(32'd2, 64'hFFFF_FFFF, 32'd0, '1, 32'd0, 32'd0,
                                            5'd0, 5'd0));
        dir_table[6]  = stim_row(OP_READ, 32'h0, 5'd31, 1'b0, zero_word);
        dir_table[7]  = stim_row(OP_ADD, 32'h1, 5'd0, 1'b0, zero_word);
        dir_table[8]  = stim_row(OP_ADD, 32'h7FFF_FFFF, 5'd0, 1'b0, zero_word);
        dir_table[9]  = stim_row(OP_ADD, 32'h8000_0000, 5'd0, 1'b0, zero_word);
        dir_table[10] = stim_row(OP_ADD, 32'h2, 5'd0, 1'b0, zero_word);
        dir_table[11] = stim_row(OP_ADD, 32'h3, 5'd0, 1'b0, zero_word);
        dir_table[12] = stim_row(OP_ADD, 32'h4, 5'd0, 1'b0, zero_word);
        dir_table[13] = stim_row(OP_ADD, 32'h4000_0000, 5'd0, 1'b0, zero_word);
        dir_table[14] = stim_row(OP_READ, 32'h0, 5'd31, 1'b0, zero_word);
        dir_table[15] = stim_row(OP_READ, 32'h0, 5'd1, 1'b0, zero_word);
        dir_table[16] = stim_row(OP_READ, 32'h0, 5'd2, 1'b0, zero_word);
        dir_table[17] = stim_row(OP_READ, 32'h0, 5'd3, 1'b0, zero_word);
        dir_table[18] = stim_row(OP_READ, '1, 5'd30, 1'b0, zero_word);
        dir_table[19] = stim_row(OP_ADD, 32'h0, 5'd0, 1'b0, zero_word);
        dir_table[20] = stim_row(OP_ADD, '1, 5'd0, 1'b0, zero_word);
        dir_table[21] = stim_row(OP_READ, 32'h0, 5'd0, 1'b0, zero_word);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) pending_words.push_back(dir_table[i]);
        wait_drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_wanted   = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w.operation   = ($urandom_range(99) < 20) ? OP_READ : OP_ADD;
                w.sample_size = (w.operation == OP_ADD) ? random_size() : 32'($urandom);
                w.bin_select  = SEL_W'($urandom_range(NBINS - 1));
                pending_words.push_back(stim_row(w.operation, w.sample_size,
                                                 w.bin_select, 1'b0, zero_word));
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words in (%0d reads, %0d adds with the top bit set), %0d out",
                 words_in, reads_in, oversized_in, words_out);
        $display("final count %0d, bins %0d..%0d, %0d mismatches",
                 pr_count, pr_lo, pr_hi, mismatches);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ssh_pkg.sv
rtl/ssh_bin_mem.sv
rtl/ssh_mean_div.sv
rtl/size_stats_log2_histogram.sv
dv/tb_size_stats_log2_histogram.sv
